/* src/rhcl_pkg.sv */
`default_nettype none

package rhcl_pkg;

   localparam int SAMPLE_W = 16;
   localparam int HUE_W = 16;
   localparam int CHROMA_W = 16;
   localparam int LIGHT_W = 17;

   // quotient n/(3c) scaled by 2^Q_BITS, one integer bit above the fraction
   localparam int Q_BITS = 30;
   localparam int QUOT_BITS = Q_BITS + 1;

   // floor(pi * 2^30)
   localparam int PI_W = 32;
   localparam logic [PI_W-1:0] PI_Q30 = 32'hC90FDAA2;

   // split point of the quotient for the two partial products
   localparam int MUL_SPLIT = 16;

   localparam int FRONT_STAGES = 2;
   localparam int MUL_STAGES = 2;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [HUE_W-1:0]    hue;
      logic [CHROMA_W-1:0] chroma;
      logic [LIGHT_W-1:0]  lightness_halves;
      logic                gray;
   } result_type;

endpackage

`default_nettype wire

/* src/rgb_to_hue_chroma_lightness.sv */
// Converts one RGB pixel per clock into hue (radians, HUE_FRAC_BITS fraction
// bits), chroma (max - min), lightness in halves (max + min) and a gray flag.
// A pixel is taken whenever start is high and busy is low; busy is high only
// while reset is asserted. Every pixel comes out as a one-cycle rsp_strobe
// pulse with rsp_data, in input order; the receiver cannot stall, so results
// must be captured on the strobe. The pipeline holds two front-end stages,
// the hue divider, which resolves one of 31 quotient bits per stage, two
// multiplier stages and the output register.
// Gray pixels give hue 0 with gray set.

`default_nettype none

module rgb_to_hue_chroma_lightness #(
   parameter int SAMPLE_BITS = 16,
   parameter int HUE_FRAC_BITS = 13
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire rhcl_pkg::pixel_type    req_data,
   output logic                        busy,
   output logic                        rsp_strobe,
   output rhcl_pkg::result_type        rsp_data
);

   localparam int S = SAMPLE_BITS;
   localparam int DEN_W = S + 2;
   localparam int SIDE_W = 1 + (S + 1) + S;
   localparam int QB = rhcl_pkg::QUOT_BITS;
   localparam int HW = rhcl_pkg::HUE_W;
   localparam int CW = rhcl_pkg::CHROMA_W;
   localparam int LW = rhcl_pkg::LIGHT_W;
   localparam int LATENCY = rhcl_pkg::FRONT_STAGES + QB + rhcl_pkg::MUL_STAGES + 1;

   logic accept;

   logic front_valid;
   logic [DEN_W:0] front_num;
   logic [DEN_W-1:0] front_den;
   logic [S-1:0] front_chroma;
   logic [S:0] front_lsum;
   logic front_gray;
   logic [SIDE_W-1:0] front_side;

   logic div_valid;
   logic [QB-1:0] div_quot;
   logic [SIDE_W-1:0] div_side;

   logic mul_valid;
   logic [HW-1:0] mul_hue;
   logic [SIDE_W-1:0] mul_side;

   logic [S-1:0] out_chroma;
   logic [S:0] out_lsum;
   logic out_gray;

   logic strobe_ff;
   rhcl_pkg::result_type data_ff;
   rhcl_pkg::result_type data_in;

   assign busy = reset;
   assign accept = start && !busy;

   rhcl_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_pixel   (req_data),
      .out_valid  (front_valid),
      .out_num    (front_num),
      .out_den    (front_den),
      .out_chroma (front_chroma),
      .out_lsum   (front_lsum),
      .out_gray   (front_gray)
   );

   assign front_side = {front_gray, front_lsum, front_chroma};

   rhcl_div #(
      .DEN_W  (DEN_W),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_num    (front_num),
      .in_den    (front_den),
      .in_side   (front_side),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   rhcl_mul #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .SIDE_W        (SIDE_W)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_quot   (div_quot),
      .in_side   (div_side),
      .out_valid (mul_valid),
      .out_hue   (mul_hue),
      .out_side  (mul_side)
   );

   assign {out_gray, out_lsum, out_chroma} = mul_side;

   // force hue to zero on gray pixels
   always_comb begin
      data_in.hue = out_gray ? '0 : mul_hue;
      data_in.chroma = CW'(out_chroma);
      data_in.lightness_halves = LW'(out_lsum);
      data_in.gray = out_gray;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= mul_valid;
      end
      data_ff <= data_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data = data_ff;

   a_every_transfer_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted pixel produced no result");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without matching accepted pixel");

   a_gray_hue_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.gray) |-> (rsp_data.hue == '0))
      else $error("gray pixel with nonzero hue");

endmodule

`default_nettype wire

/* src/rhcl_front.sv */
`default_nettype none

module rhcl_front #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   input  wire rhcl_pkg::pixel_type    in_pixel,
   output logic                        out_valid,
   output logic [SAMPLE_BITS+2:0]      out_num,
   output logic [SAMPLE_BITS+1:0]      out_den,
   output logic [SAMPLE_BITS-1:0]      out_chroma,
   output logic [SAMPLE_BITS:0]        out_lsum,
   output logic                        out_gray
);

   localparam int S = SAMPLE_BITS;
   localparam int NUM_W = S + 3;
   localparam int DEN_W = S + 2;
   localparam int DIFF_W = S + 1;

   logic [S-1:0] r;
   logic [S-1:0] g;
   logic [S-1:0] b;
   logic [S-1:0] mx;
   logic [S-1:0] mn;
   rhcl_pkg::sector_type sector_in;
   logic signed [DIFF_W-1:0] diff_in;

   logic valid1_ff;
   logic [S-1:0] chroma1_ff;
   logic [S:0] lsum1_ff;
   rhcl_pkg::sector_type sector1_ff;
   logic signed [DIFF_W-1:0] diff1_ff;

   logic [NUM_W-1:0] base;
   logic [NUM_W-1:0] six_c;
   logic [NUM_W:0] n_raw;
   logic [NUM_W-1:0] num_in;
   logic [DEN_W-1:0] den_in;
   logic gray_in;

   logic valid2_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [S-1:0] chroma2_ff;
   logic [S:0] lsum2_ff;
   logic gray_ff;

   // stage 1: max, min, sector and channel difference
   always_comb begin
      r = S'(in_pixel.red);
      g = S'(in_pixel.green);
      b = S'(in_pixel.blue);
      if (b >= r && b >= g) begin
         sector_in = rhcl_pkg::SECTOR_BLUE;
         mx = b;
         diff_in = $signed({1'b0, r}) - $signed({1'b0, g});
      end else if (g >= r) begin
         sector_in = rhcl_pkg::SECTOR_GREEN;
         mx = g;
         diff_in = $signed({1'b0, b}) - $signed({1'b0, r});
      end else begin
         sector_in = rhcl_pkg::SECTOR_RED;
         mx = r;
         diff_in = $signed({1'b0, g}) - $signed({1'b0, b});
      end
      mn = r;
      if (g < mn) begin
         mn = g;
      end
      if (b < mn) begin
         mn = b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
      chroma1_ff <= mx - mn;
      lsum1_ff <= {1'b0, mx} + {1'b0, mn};
      sector1_ff <= sector_in;
      diff1_ff <= diff_in;
   end

   // stage 2: numerator k*c + diff wrapped into [0, 6c), divisor 3c
   always_comb begin
      unique case (sector1_ff)
         rhcl_pkg::SECTOR_BLUE:  base = NUM_W'({chroma1_ff, 2'b00});
         rhcl_pkg::SECTOR_GREEN: base = NUM_W'({chroma1_ff, 1'b0});
         rhcl_pkg::SECTOR_RED:   base = '0;
         default:                base = '0;
      endcase
      six_c = NUM_W'({chroma1_ff, 2'b00}) + NUM_W'({chroma1_ff, 1'b0});
      n_raw = {1'b0, base}
            + {{(NUM_W + 1 - DIFF_W){diff1_ff[DIFF_W-1]}}, diff1_ff};
      if (n_raw[NUM_W]) begin
         num_in = n_raw[NUM_W-1:0] + six_c;
      end else begin
         num_in = n_raw[NUM_W-1:0];
      end
      den_in = DEN_W'({chroma1_ff, 1'b0}) + DEN_W'(chroma1_ff);
      gray_in = (chroma1_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      chroma2_ff <= chroma1_ff;
      lsum2_ff <= lsum1_ff;
      gray_ff <= gray_in;
   end

   assign out_valid = valid2_ff;
   assign out_num = num_ff;
   assign out_den = den_ff;
   assign out_chroma = chroma2_ff;
   assign out_lsum = lsum2_ff;
   assign out_gray = gray_ff;

endmodule

`default_nettype wire

/* src/rhcl_div.sv */
`default_nettype none

module rhcl_div #(
   parameter int DEN_W = 18,
   parameter int SIDE_W = 1
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  in_valid,
   input  wire [DEN_W:0]                        in_num,
   input  wire [DEN_W-1:0]                      in_den,
   input  wire [SIDE_W-1:0]                     in_side,
   output logic                                 out_valid,
   output logic [rhcl_pkg::QUOT_BITS-1:0]       out_quot,
   output logic [SIDE_W-1:0]                    out_side
);

   localparam int QB = rhcl_pkg::QUOT_BITS;
   localparam int PW = DEN_W + 1;

   logic [QB-1:0] valid_ff;
   logic [DEN_W-1:0] rem_ff [QB];
   logic [DEN_W-1:0] rem_in [QB];
   logic [DEN_W-1:0] den_ff [QB];
   logic [QB-1:0] quot_ff [QB];
   logic [QB-1:0] quot_in [QB];
   logic [SIDE_W-1:0] side_ff [QB];

   logic [QB-1:0] valid_src;
   logic [PW-1:0] part_src [QB];
   logic [DEN_W-1:0] den_src [QB];
   logic [QB-1:0] quot_src [QB];
   logic [SIDE_W-1:0] side_src [QB];
   logic [QB-1:0] fits;

   // each stage takes its operands from the stage before it
   for (genvar i = 0; i < QB; i++) begin : g_src
      if (i == 0) begin : g_first
         assign valid_src[i] = in_valid;
         assign part_src[i] = in_num;
         assign den_src[i] = in_den;
         assign quot_src[i] = '0;
         assign side_src[i] = in_side;
      end else begin : g_next
         assign valid_src[i] = valid_ff[i-1];
         assign part_src[i] = {rem_ff[i-1], 1'b0};
         assign den_src[i] = den_ff[i-1];
         assign quot_src[i] = quot_ff[i-1];
         assign side_src[i] = side_ff[i-1];
      end
   end

   // one quotient bit per stage: compare, subtract, shift in
   always_comb begin
      for (int i = 0; i < QB; i++) begin
         fits[i] = (part_src[i] >= {1'b0, den_src[i]});
         if (fits[i]) begin
            rem_in[i] = DEN_W'(part_src[i] - {1'b0, den_src[i]});
         end else begin
            rem_in[i] = DEN_W'(part_src[i]);
         end
         quot_in[i] = {quot_src[i][QB-2:0], fits[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_src;
      end
      for (int i = 0; i < QB; i++) begin
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_src[i];
         quot_ff[i] <= quot_in[i];
         side_ff[i] <= side_src[i];
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_quot = quot_ff[QB-1];
   assign out_side = side_ff[QB-1];

endmodule

`default_nettype wire

/* src/rhcl_mul.sv */
`default_nettype none

module rhcl_mul #(
   parameter int HUE_FRAC_BITS = 13,
   parameter int SIDE_W = 1
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  in_valid,
   input  wire [rhcl_pkg::QUOT_BITS-1:0]        in_quot,
   input  wire [SIDE_W-1:0]                     in_side,
   output logic                                 out_valid,
   output logic [rhcl_pkg::HUE_W-1:0]           out_hue,
   output logic [SIDE_W-1:0]                    out_side
);

   localparam int QB = rhcl_pkg::QUOT_BITS;
   localparam int SPLIT = rhcl_pkg::MUL_SPLIT;
   localparam int PIW = rhcl_pkg::PI_W;
   localparam int HW = rhcl_pkg::HUE_W;
   localparam int HI_P_W = QB - SPLIT + PIW;
   localparam int LO_P_W = SPLIT + PIW;
   localparam int PROD_W = QB + PIW;
   localparam int HUE_SHIFT = 2 * rhcl_pkg::Q_BITS - HUE_FRAC_BITS;

   logic [HI_P_W-1:0] p_hi_in;
   logic [LO_P_W-1:0] p_lo_in;
   logic [PROD_W-1:0] sum;
   logic [HW-1:0] hue_in;

   logic valid1_ff;
   logic [HI_P_W-1:0] p_hi_ff;
   logic [LO_P_W-1:0] p_lo_ff;
   logic [SIDE_W-1:0] side1_ff;

   logic valid2_ff;
   logic [HW-1:0] hue_ff;
   logic [SIDE_W-1:0] side2_ff;

   // stage 1: two partial products of the quotient times pi
   always_comb begin
      p_hi_in = HI_P_W'(in_quot[QB-1:SPLIT]) * HI_P_W'(rhcl_pkg::PI_Q30);
      p_lo_in = LO_P_W'(in_quot[SPLIT-1:0]) * LO_P_W'(rhcl_pkg::PI_Q30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
      p_hi_ff <= p_hi_in;
      p_lo_ff <= p_lo_in;
      side1_ff <= in_side;
   end

   // stage 2: combine and drop the extra fraction bits
   always_comb begin
      sum = {p_hi_ff, {SPLIT{1'b0}}} + PROD_W'(p_lo_ff);
      hue_in = HW'(sum >> HUE_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      hue_ff <= hue_in;
      side2_ff <= side1_ff;
   end

   assign out_valid = valid2_ff;
   assign out_hue = hue_ff;
   assign out_side = side2_ff;

endmodule

`default_nettype wire

/* verif/rgb_to_hue_chroma_lightness_test.sv */
`timescale 1ns / 1ps

module rgb_to_hue_chroma_lightness_test;

   localparam int HUE_FRAC = 13;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 48;
   localparam int RANDOM_PIXELS = 540;

   typedef struct {
      rhcl_pkg::pixel_type px;
      int unsigned         gap_pct;
   } pending_pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   rhcl_pkg::pixel_type  req_data = '0;
   logic                 busy;
   logic                 rsp_strobe;
   rhcl_pkg::result_type rsp_data;

   pending_pixel_type    pending_pixels[$];
   rhcl_pkg::result_type expected_results[$];
   int unsigned          accepted_pixels = 0;
   int unsigned          total_pixels = 0;
   int unsigned          error_count = 0;
   int unsigned          idle_cycles = 0;

   rgb_to_hue_chroma_lightness #(
      .SAMPLE_BITS(rhcl_pkg::SAMPLE_W),
      .HUE_FRAC_BITS(HUE_FRAC)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   function automatic rhcl_pkg::result_type convert_pixel(rhcl_pkg::pixel_type px);
      logic [rhcl_pkg::SAMPLE_W-1:0] hi;
      logic [rhcl_pkg::SAMPLE_W-1:0] lo;
      longint                        n;
      longint unsigned               c;
      longint unsigned               x;
      longint unsigned               prod;
      rhcl_pkg::result_type          res;
      hi = px.red;
      if (px.green > hi) hi = px.green;
      if (px.blue > hi) hi = px.blue;
      lo = px.red;
      if (px.green < lo) lo = px.green;
      if (px.blue < lo) lo = px.blue;
      c = longint'(hi) - longint'(lo);
      res.chroma = rhcl_pkg::CHROMA_W'(c);
      res.lightness_halves = rhcl_pkg::LIGHT_W'({1'b0, hi} + {1'b0, lo});
      res.gray = 1'b1;
      res.hue = '0;
      if (c != 0) begin
         res.gray = 1'b0;
         if (hi == px.blue) begin
            n = 4 * longint'(c) + longint'(px.red) - longint'(px.green);
         end else if (hi == px.green) begin
            n = 2 * longint'(c) + longint'(px.blue) - longint'(px.red);
         end else begin
            n = longint'(px.green) - longint'(px.blue);
         end
         if (n < 0) n = n + 6 * longint'(c);
         x = (unsigned'(n) << rhcl_pkg::Q_BITS) / (3 * c);
         prod = x * 64'(rhcl_pkg::PI_Q30);
         res.hue = rhcl_pkg::HUE_W'(prod >> (2 * rhcl_pkg::Q_BITS - HUE_FRAC));
      end
      return res;
   endfunction

   task automatic add_pixel(input int unsigned r, input int unsigned g, input int unsigned b,
                            input int unsigned gap_pct);
      pending_pixel_type item;
      item.px.red = rhcl_pkg::SAMPLE_W'(r);
      item.px.green = rhcl_pkg::SAMPLE_W'(g);
      item.px.blue = rhcl_pkg::SAMPLE_W'(b);
      item.gap_pct = gap_pct;
      pending_pixels.push_back(item);
   endtask

   task automatic add_random_pixel(input int unsigned gap_pct);
      int unsigned v[3];
      int unsigned base;
      int unsigned pick;
      base = $urandom_range(65535);
      for (int i = 0; i < 3; i++) v[i] = $urandom_range(65535);
      case ($urandom_range(9))
         5: begin
            v[0] = base;
            v[1] = base;
            v[2] = base;
         end
         6: begin
            pick = $urandom_range(2);
            v[pick] = base;
            v[(pick + 1) % 3] = base;
            v[(pick + 2) % 3] = $urandom_range(base);
         end
         7: begin
            base = $urandom_range(65532);
            for (int i = 0; i < 3; i++) v[i] = base + $urandom_range(3);
         end
         8: begin
            for (int i = 0; i < 3; i++) begin
               pick = $urandom_range(2);
               v[i] = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(65535);
            end
         end
         default: begin
         end
      endcase
      add_pixel(v[0], v[1], v[2], gap_pct);
   endtask

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      add_pixel(0, 0, 0, 0);
      add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
      add_pixel(16'hFFFF, 0, 0, 0);
      add_pixel(0, 16'hFFFF, 0, 0);
      add_pixel(0, 0, 16'hFFFF, 0);
      add_pixel(16'hFFFF, 16'hFFFF, 0, 0);
      add_pixel(0, 16'hFFFF, 16'hFFFF, 0);
      add_pixel(16'hFFFF, 0, 16'hFFFF, 0);
      add_pixel(16'hFFFF, 0, 1, 0);
      add_pixel(16'hFFFF, 1, 0, 0);
      add_pixel(1, 0, 0, 0);
      add_pixel(0, 1, 1, 0);
      add_pixel(16'h1234, 16'h1234, 16'h1233, 0);
      add_pixel(16'h8000, 16'h4000, 16'hC000, 0);
      add_pixel(16'hFFFF, 16'hFFFE, 16'hFFFF, 0);
      add_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 0);
      add_pixel(16'h5555, 16'hAAAA, 0, 0);
      add_pixel(0, 16'hFFFF, 16'hFFFE, 0);
      add_pixel(16'hFFFE, 16'hFFFF, 0, 0);
      add_pixel(16'h0001, 16'hFFFF, 16'h0000, 0);
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         case (i * 4 / RANDOM_PIXELS)
            0: add_random_pixel(0);
            1: add_random_pixel(76);
            2: add_random_pixel(30);
            default: add_random_pixel(0);
         endcase
      end
      total_pixels = pending_pixels.size();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (accepted_pixels < total_pixels || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // driver: advance to the next pending pixel after each transfer
   always @(posedge clock) begin
      pending_pixel_type item;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_results.push_back(convert_pixel(req_data));
            accepted_pixels++;
         end
         if (!start || !busy) begin
            if (pending_pixels.size() != 0 &&
                $urandom_range(99) >= pending_pixels[0].gap_pct) begin
               item = pending_pixels.pop_front();
               req_data <= item.px;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rhcl_pkg::result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: hue %0d chroma %0d", rsp_data.hue, rsp_data.chroma);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.hue !== want.hue) begin
               $error("hue: expected %0d, got %0d", want.hue, rsp_data.hue);
               error_count++;
            end
            if (rsp_data.chroma !== want.chroma) begin
               $error("chroma: expected %0d, got %0d", want.chroma, rsp_data.chroma);
               error_count++;
            end
            if (rsp_data.lightness_halves !== want.lightness_halves) begin
               $error("lightness_halves: expected %0d, got %0d",
                      want.lightness_halves, rsp_data.lightness_halves);
               error_count++;
            end
            if (rsp_data.gray !== want.gray) begin
               $error("gray: expected %0d, got %0d", want.gray, rsp_data.gray);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy && !reset) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
